[hdl/fifc_pkg.sv]
`default_nettype none

package fifc_pkg;

    // Operation selected by each input beat.
    typedef enum logic [1:0] {
        ACT_F2I   = 2'd0,
        ACT_I2F   = 2'd1,
        ACT_F2F   = 2'd2,
        ACT_WIDTH = 2'd3
    } action_t;

    // Class of a floating-point operand.
    typedef enum logic [1:0] {
        CLS_FIN = 2'd0,
        CLS_INF = 2'd1,
        CLS_NAN = 2'd2
    } fclass_t;

    localparam int SGL_WIDTH = 32;
    localparam int DBL_WIDTH = 64;

    // Fields that travel unchanged down the whole pipeline.
    typedef struct packed {
        action_t     action;
        logic [63:0] value;
        logic        src_dbl;
        logic        tgt_dbl;
        logic        uns;
        logic [6:0]  width;
        logic        sign;
        fclass_t     cls;
        logic [51:0] frac;
    } ctl_t;

    typedef struct packed {
        ctl_t               ctl;
        logic [63:0]        norm_in;
        logic signed [12:0] scale;
    } dec_t;

    typedef struct packed {
        ctl_t               ctl;
        logic [63:0]        norm_in;
        logic signed [12:0] scale;
        logic [6:0]         lzc;
    } lz_t;

    typedef struct packed {
        ctl_t               ctl;
        logic [63:0]        norm;
        logic signed [12:0] expo;
        logic               zero;
    } nrm_t;

    typedef struct packed {
        ctl_t               ctl;
        logic [63:0]        norm;
        logic signed [12:0] expo;
        logic               zero;
        logic [52:0]        q;
        logic               round_up;
        logic               inexact;
        logic [63:0]        mag;
        logic               dropped;
        logic               big;
    } rnd_t;

    typedef struct packed {
        logic [63:0] result;
        logic        rdbl;
        logic        exact;
        logic        ovf;
        logic        need;
    } res_t;

endpackage

`default_nettype wire

[hdl/float_int_format_converter.sv]
// Channel   Direction  tdata (low bit first)                       tuser (low bit first)
// s_*       in         value_bits[63:0], target_width[70:64], pad  action[1:0], source_is_double,
//                                                                  is_unsigned
// m_*       out        result_bits[63:0]                           result_is_double, exact,
//                                                                  overflow, needs_double
//
// Every conversion passes from input beat to output beat through the stages decode, leading-zero
// count, normalize, round/shift, pack. The depth is set by the 64-bit leading-zero search
// and the 128-bit alignment shifter, each of which has its own stage.
// One beat is accepted per cycle unless the output stalls; all stages advance together
// whenever the output stage is empty or being taken, so a stall holds every stage in place.
// Reset (rst_n low, asynchronous) clears only the stage valid bits.
`default_nettype none

module float_int_format_converter
    import fifc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // value_bits[63:0], target_width[70:64], zero pad
    input  wire logic [3:0]  s_tuser,   // action[1:0], source_is_double, is_unsigned
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // result_bits[63:0]
    output logic [3:0]       m_tuser    // result_is_double, exact, overflow, needs_double
);

    logic [4:0] vld_reg;
    logic       adv;

    dec_t dec_reg, dec_next;
    lz_t  lz_reg,  lz_next;
    nrm_t nrm_reg, nrm_next;
    rnd_t rnd_reg, rnd_next;
    res_t res_reg, res_next;

    // The pipeline moves as one unit whenever the output register can take a new beat.
    assign adv      = !vld_reg[4] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[4];
    assign m_tdata  = res_reg.result;
    assign m_tuser  = {res_reg.need, res_reg.ovf, res_reg.exact, res_reg.rdbl};

    // Stage 1: decode the operand into sign, class, significand and scale.
    always_comb
    begin
        logic [63:0] v;
        logic [6:0]  tw;
        logic [10:0] ed;
        logic [7:0]  es;
        v  = s_tdata[63:0];
        tw = s_tdata[70:64];
        ed = v[62:52];
        es = v[30:23];
        dec_next.ctl.action  = action_t'(s_tuser[1:0]);
        dec_next.ctl.value   = v;
        dec_next.ctl.src_dbl = s_tuser[2];
        dec_next.ctl.uns     = s_tuser[3];
        dec_next.ctl.tgt_dbl = (tw != 7'(SGL_WIDTH));
        dec_next.ctl.width   = (tw == 7'd0 || tw > 7'(DBL_WIDTH)) ? 7'(DBL_WIDTH) : tw;
        if (dec_next.ctl.action == ACT_I2F)
        begin
            dec_next.ctl.sign = !s_tuser[3] && v[63];
            dec_next.ctl.cls  = CLS_FIN;
            dec_next.ctl.frac = 52'd0;
            dec_next.norm_in  = dec_next.ctl.sign ? (64'd0 - v) : v;
            dec_next.scale    = 13'sd0;
        end
        else if (s_tuser[2])
        begin
            dec_next.ctl.sign = v[63];
            dec_next.ctl.cls  = (&ed) ? ((|v[51:0]) ? CLS_NAN : CLS_INF) : CLS_FIN;
            dec_next.ctl.frac = v[51:0];
            dec_next.norm_in  = {11'd0, |ed, v[51:0]};
            dec_next.scale    = (ed == 11'd0) ? -13'sd1074
                                              : $signed({2'b00, ed}) - 13'sd1075;
        end
        else
        begin
            dec_next.ctl.sign = v[31];
            dec_next.ctl.cls  = (&es) ? ((|v[22:0]) ? CLS_NAN : CLS_INF) : CLS_FIN;
            dec_next.ctl.frac = {29'd0, v[22:0]};
            dec_next.norm_in  = {40'd0, |es, v[22:0]};
            dec_next.scale    = (es == 8'd0) ? -13'sd149
                                             : $signed({5'b00000, es}) - 13'sd150;
        end
    end

    // Stage 2: leading-zero count of the magnitude.
    always_comb
    begin
        logic [6:0] lz;
        lz = 7'd64;
        for (int i = 0; i < 64; i++)
        begin
            if (dec_reg.norm_in[i])
            begin
                lz = 7'(63 - i);
            end
        end
        lz_next.ctl     = dec_reg.ctl;
        lz_next.norm_in = dec_reg.norm_in;
        lz_next.scale   = dec_reg.scale;
        lz_next.lzc     = lz;
    end

    // Stage 3: normalize so the leading one sits at bit 63; expo is its weight.
    always_comb
    begin
        logic [6:0] n;
        n = 7'd64 - lz_reg.lzc;
        nrm_next.ctl  = lz_reg.ctl;
        nrm_next.norm = lz_reg.norm_in << lz_reg.lzc[5:0];
        nrm_next.expo = $signed({6'd0, n}) - 13'sd1 + lz_reg.scale;
        nrm_next.zero = lz_reg.lzc[6];
    end

    // Stage 4: align for rounding and for truncation to an integer.
    always_comb
    begin
        logic [6:0]         sh;
        logic signed [12:0] sub_sh;
        logic [127:0]       wide;
        logic               guard;
        logic               sticky;
        logic [6:0]         lsh;
        sub_sh = -13'sd86 - nrm_reg.expo;
        if (nrm_reg.ctl.action == ACT_I2F)
        begin
            sh = nrm_reg.ctl.tgt_dbl ? 7'd11 : 7'd40;
        end
        else if (nrm_reg.expo >= -13'sd126)
        begin
            sh = 7'd40;
        end
        else if (sub_sh > 13'sd127)
        begin
            sh = 7'd127;
        end
        else
        begin
            sh = sub_sh[6:0];
        end
        wide   = {nrm_reg.norm, 64'd0} >> sh;
        guard  = wide[63];
        sticky = |wide[62:0];

        rnd_next.ctl      = nrm_reg.ctl;
        rnd_next.norm     = nrm_reg.norm;
        rnd_next.expo     = nrm_reg.expo;
        rnd_next.zero     = nrm_reg.zero;
        rnd_next.q        = wide[116:64];
        rnd_next.round_up = guard && (sticky || wide[64]);
        rnd_next.inexact  = guard || sticky;

        lsh = nrm_reg.expo[6:0] + 7'd1;
        rnd_next.mag     = 64'd0;
        rnd_next.dropped = 1'b0;
        rnd_next.big     = 1'b0;
        if (nrm_reg.zero)
        begin
            rnd_next.mag = 64'd0;
        end
        else if (nrm_reg.expo < 13'sd0)
        begin
            rnd_next.dropped = 1'b1;
        end
        else if (nrm_reg.expo > 13'sd63)
        begin
            rnd_next.big = 1'b1;
        end
        else
        begin
            rnd_next.mag     = nrm_reg.norm >> (6'd63 - nrm_reg.expo[5:0]);
            rnd_next.dropped = (nrm_reg.norm << lsh) != 64'd0;
        end
    end

    // Stage 5: apply rounding, range checks and packing for the selected action.
    always_comb
    begin
        ctl_t               c;
        logic [53:0]        sig_r;
        logic               carry;
        logic signed [12:0] e_adj;
        logic signed [12:0] e_bias;
        logic [24:0]        r_s;
        logic [63:0]        d2s_res;
        logic               d2s_exact;
        logic [63:0]        lim;
        logic [63:0]        minv;
        logic               ovf;
        c = rnd_reg.ctl;
        res_next = '0;
        sig_r  = '0;
        carry  = 1'b0;
        e_adj  = '0;
        e_bias = '0;
        lim    = '0;
        minv   = '0;
        ovf    = 1'b0;

        // Double to single, shared by the format conversion and the width query.
        r_s = {1'b0, rnd_reg.q[23:0]} + {24'd0, rnd_reg.round_up};
        if (c.cls == CLS_NAN)
        begin
            d2s_res   = {32'd0, c.sign, 8'hff, 1'b1, c.frac[50:29]};
            d2s_exact = 1'b0;
        end
        else if (c.cls == CLS_INF)
        begin
            d2s_res   = {32'd0, c.sign, 8'hff, 23'd0};
            d2s_exact = 1'b1;
        end
        else if (rnd_reg.zero)
        begin
            d2s_res   = {32'd0, c.sign, 31'd0};
            d2s_exact = 1'b1;
        end
        else if (rnd_reg.expo >= -13'sd126)
        begin
            e_adj  = rnd_reg.expo + {12'd0, r_s[24]};
            e_bias = e_adj + 13'sd127;
            if (e_adj > 13'sd127)
            begin
                d2s_res   = {32'd0, c.sign, 8'hff, 23'd0};
                d2s_exact = 1'b0;
            end
            else
            begin
                d2s_res   = {32'd0, c.sign, e_bias[7:0], r_s[24] ? 23'd0 : r_s[22:0]};
                d2s_exact = !rnd_reg.inexact;
            end
        end
        else
        begin
            // Too small for a normal single: subnormal or signed zero.
            d2s_res   = {32'd0, c.sign, 7'd0, r_s[23:0]};
            d2s_exact = !rnd_reg.inexact;
        end

        case (c.action)
            ACT_F2I:
            begin
                lim  = 64'd1 << (c.width - 7'd1);
                minv = c.uns ? 64'd0 : (64'd0 - lim);
                ovf  = (c.cls != CLS_FIN) || rnd_reg.big;
                if (c.uns)
                begin
                    if (c.sign && rnd_reg.mag != 64'd0)
                    begin
                        ovf = 1'b1;
                    end
                    if (c.width < 7'd64 && (rnd_reg.mag >> c.width) != 64'd0)
                    begin
                        ovf = 1'b1;
                    end
                end
                else if (c.sign ? (rnd_reg.mag > lim) : (rnd_reg.mag >= lim))
                begin
                    ovf = 1'b1;
                end
                res_next.ovf = ovf;
                if (ovf)
                begin
                    res_next.result = minv;
                    res_next.exact  = 1'b0;
                end
                else
                begin
                    res_next.result = (c.sign && !c.uns) ? (64'd0 - rnd_reg.mag) : rnd_reg.mag;
                    res_next.exact  = !rnd_reg.dropped;
                end
            end
            ACT_I2F:
            begin
                res_next.rdbl = c.tgt_dbl;
                sig_r = {1'b0, rnd_reg.q} + {53'd0, rnd_reg.round_up};
                carry = c.tgt_dbl ? sig_r[53] : sig_r[24];
                e_adj = rnd_reg.expo + {12'd0, carry};
                if (rnd_reg.zero)
                begin
                    res_next.result = 64'd0;
                    res_next.exact  = 1'b1;
                end
                else if (c.tgt_dbl)
                begin
                    e_bias = e_adj + 13'sd1023;
                    res_next.result = {c.sign, e_bias[10:0], carry ? 52'd0 : sig_r[51:0]};
                    res_next.exact  = !rnd_reg.inexact;
                end
                else
                begin
                    e_bias = e_adj + 13'sd127;
                    res_next.result = {32'd0, c.sign, e_bias[7:0],
                                       carry ? 23'd0 : sig_r[22:0]};
                    res_next.exact  = !rnd_reg.inexact;
                end
            end
            ACT_F2F:
            begin
                res_next.rdbl = c.tgt_dbl;
                if (c.src_dbl == c.tgt_dbl)
                begin
                    res_next.result = c.src_dbl ? c.value : {32'd0, c.value[31:0]};
                    res_next.exact  = 1'b1;
                end
                else if (c.tgt_dbl)
                begin
                    // Single to double is always exact.
                    res_next.exact = 1'b1;
                    e_bias = rnd_reg.expo + 13'sd1023;
                    if (c.cls == CLS_NAN)
                    begin
                        // The quiet bit overlays the top payload bit.
                        res_next.result = {c.sign, 11'h7ff, 1'b1, c.frac[21:0], 29'd0};
                    end
                    else if (c.cls == CLS_INF)
                    begin
                        res_next.result = {c.sign, 11'h7ff, 52'd0};
                    end
                    else if (rnd_reg.zero)
                    begin
                        res_next.result = {c.sign, 63'd0};
                    end
                    else
                    begin
                        res_next.result = {c.sign, e_bias[10:0], rnd_reg.norm[62:11]};
                    end
                end
                else
                begin
                    res_next.result = d2s_res;
                    res_next.exact  = d2s_exact;
                end
            end
            ACT_WIDTH:
            begin
                res_next.need = c.src_dbl && (c.cls == CLS_FIN) && !d2s_exact;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[3:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dec_reg <= dec_next;
            lz_reg  <= lz_next;
            nrm_reg <= nrm_next;
            rnd_reg <= rnd_next;
            res_reg <= res_next;
        end
    end

    // Overflow is only ever raised by a float to integer conversion.
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] && adv && (rnd_reg.ctl.action != ACT_F2I) |=> !m_tuser[2])
        else $error("overflow raised outside float to integer");

    // An overflowing conversion never claims to be exact.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> !m_tuser[1])
        else $error("overflow with exact set");

    // The width query leaves the result word and format flag clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] && adv && (rnd_reg.ctl.action == ACT_WIDTH)
        |=> (m_tdata == 64'd0) && !m_tuser[0] && !m_tuser[1])
        else $error("width query produced a result word");

endmodule

`default_nettype wire
